/* hdl/tarb_pkg.sv */
// ----------------------------------------------------------------------------
// tarb_pkg: shared types and constants of the timestamped audio ring buffer
// Field widths, command codes, controller state codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tarb_pkg;

  localparam int TIME_W = 64;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic is_write;   // accepted write word
    logic is_read;    // accepted read word: issue memory read, latch time
    logic is_clear;   // accepted clear word: rewind sweep, drop watermark
    logic clr_step;   // write zero at sweep address and advance
    logic load_out;   // load result register
  } tarb_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;   // sweep address is at the last entry
  } tarb_sts_t;

endpackage

/* hdl/tarb_channels.sv */
// ----------------------------------------------------------------------------
// tarb channels: valid/ready interfaces of the ring buffer
// Request, result and configuration channels, each with source and sink.
// ----------------------------------------------------------------------------
interface tarb_req_if;
  logic                           valid;
  logic                           ready;
  logic [tarb_pkg::CMD_W-1:0]     cmd;
  logic [tarb_pkg::TIME_W-1:0]    sample_time;
  logic                           channel;
  logic [tarb_pkg::WORD_W-1:0]    sample_in;
  logic                           last_in_batch;

  modport source (output valid, cmd, sample_time, channel, sample_in, last_in_batch,
                  input ready);
  modport sink   (input valid, cmd, sample_time, channel, sample_in, last_in_batch,
                  output ready);
endinterface

interface tarb_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tarb_pkg::WORD_W-1:0]    sample_out;
  logic                           in_window;

  modport source (output valid, sample_out, in_window, input ready);
  modport sink   (input valid, sample_out, in_window, output ready);
endinterface

interface tarb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tarb_pkg::CNT_W-1:0]     channel_count;

  modport source (output valid, channel_count, input ready);
  modport sink   (input valid, channel_count, output ready);
endinterface

/* hdl/tarb_ctrl.sv */
// ----------------------------------------------------------------------------
// tarb_ctrl: controller of the ring buffer
// Sequences the clearing sweep, request acceptance and result delivery.
// ----------------------------------------------------------------------------
module tarb_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [tarb_pkg::CMD_W-1:0] req_cmd,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  tarb_pkg::tarb_sts_t        sts,
  output tarb_pkg::tarb_ctl_t        ctl
);

  tarb_pkg::state_t state, state_next;
  logic             out_full;
  logic             accept;
  logic             out_free;

  assign req_ready = (state == tarb_pkg::ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !out_full || rsp_ready;
  assign rsp_valid = out_full;

  always_comb begin
    ctl          = '0;
    state_next   = state;
    unique case (state)
      tarb_pkg::ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = tarb_pkg::ST_IDLE;
        end
      end
      tarb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_cmd)
            tarb_pkg::CMD_WRITE: ctl.is_write = 1'b1;
            tarb_pkg::CMD_READ: begin
              ctl.is_read = 1'b1;
              state_next  = tarb_pkg::ST_READ;
            end
            tarb_pkg::CMD_CLEAR: begin
              ctl.is_clear = 1'b1;
              state_next   = tarb_pkg::ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      tarb_pkg::ST_READ: begin
        // hold the read word until the result register frees up
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = tarb_pkg::ST_IDLE;
        end
      end
      default: state_next = tarb_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tarb_pkg::ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_full <= 1'b1;
      end else if (rsp_ready) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

/* hdl/tarb_dp.sv */
// ----------------------------------------------------------------------------
// tarb_dp: datapath of the ring buffer
// Sample memory, address math, watermark, window check and result register.
// ----------------------------------------------------------------------------
module tarb_dp #(
  parameter int CAPACITY_FRAMES = 1024,
  parameter int MAX_CHANNELS    = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tarb_pkg::CNT_W-1:0]  cfg_count,
  input  logic [tarb_pkg::TIME_W-1:0] sample_time,
  input  logic                        channel,
  input  logic [tarb_pkg::WORD_W-1:0] sample_in,
  input  logic                        last_in_batch,
  input  tarb_pkg::tarb_ctl_t         ctl,
  output tarb_pkg::tarb_sts_t         sts,
  output logic [tarb_pkg::WORD_W-1:0] sample_out,
  output logic                        in_window
);

  localparam int DEPTH = CAPACITY_FRAMES * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(CAPACITY_FRAMES);
  localparam int MCW   = $clog2(MAX_CHANNELS + 1);
  localparam int CCW   = (MCW > tarb_pkg::CNT_W) ? MCW : tarb_pkg::CNT_W;
  localparam int PW    = SW + CCW;
  localparam logic [CCW-1:0]              MAX_CC = CCW'(MAX_CHANNELS);
  localparam logic [tarb_pkg::TIME_W-1:0] CAP    = tarb_pkg::TIME_W'(CAPACITY_FRAMES);
  localparam logic [AW-1:0]               LAST_A = AW'(DEPTH - 1);

  logic [tarb_pkg::WORD_W-1:0] mem [DEPTH];
  logic [tarb_pkg::WORD_W-1:0] rdata;
  logic [tarb_pkg::CNT_W-1:0]  channel_count;
  logic [CCW-1:0]              cc_raw;
  logic [CCW-1:0]              cc;
  logic [SW-1:0]               slot;
  logic [PW-1:0]               prod;
  logic [AW-1:0]               addr;
  logic                        ch_ok;
  logic [AW-1:0]               clr_addr;
  logic [tarb_pkg::TIME_W-1:0] write_end;
  logic [tarb_pkg::TIME_W-1:0] win_lo;
  logic [tarb_pkg::TIME_W-1:0] end_time;
  logic [tarb_pkg::TIME_W-1:0] rd_time;
  logic                        rd_ch_ok;
  logic                        win_hit;

  // Clamp the register to [1, MAX_CHANNELS].
  assign cc_raw = CCW'(channel_count);
  always_comb begin
    if (cc_raw == '0) begin
      cc = CCW'(1);
    end else if (cc_raw > MAX_CC) begin
      cc = MAX_CC;
    end else begin
      cc = cc_raw;
    end
  end

  assign slot  = sample_time[SW-1:0];
  assign prod  = PW'(slot) * PW'(cc) + PW'(channel);
  assign addr  = prod[AW-1:0];
  assign ch_ok = CCW'(channel) < cc;

  assign end_time     = sample_time + tarb_pkg::TIME_W'(1);
  assign sts.clr_last = (clr_addr == LAST_A);
  assign win_hit      = (rd_time >= win_lo) && (rd_time < write_end);

  always_ff @(posedge clk) begin
    if (ctl.clr_step) begin
      mem[clr_addr] <= '0;
    end else if (ctl.is_write && ch_ok) begin
      mem[addr] <= sample_in;
    end
    if (ctl.is_read) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= tarb_pkg::CNT_W'(1);
      clr_addr      <= '0;
      write_end     <= '0;
      win_lo        <= '0;
    end else begin
      if (cfg_we) begin
        channel_count <= cfg_count;
      end
      if (ctl.is_clear) begin
        clr_addr <= '0;
      end else if (ctl.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (ctl.is_clear) begin
        write_end <= '0;
      end else if (ctl.is_write && last_in_batch && (end_time > write_end)) begin
        write_end <= end_time;
      end
      win_lo <= (write_end > CAP) ? (write_end - CAP) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.is_read) begin
      rd_time  <= sample_time;
      rd_ch_ok <= ch_ok;
    end
    if (ctl.load_out) begin
      sample_out <= (win_hit && rd_ch_ok) ? rdata : '0;
      in_window  <= win_hit;
    end
  end

endmodule

/* hdl/timestamped_audio_ring_buffer.sv */
// ----------------------------------------------------------------------------
// timestamped_audio_ring_buffer: multichannel audio store indexed by sample time
// Writes, reads and clears a ring of sample words addressed by 64-bit time.
// ----------------------------------------------------------------------------
//
//  port  | role  | word
//  ------+-------+-----------------------------------------------------------
//  req   | sink  | cmd, sample_time, channel, sample_in, last_in_batch
//  rsp   | source| sample_out, in_window (one word per read command)
//  cfg   | sink  | channel_count, always ready
//
// A write or an unused command leaves the controller idle, so writes stream back to back.
// A read first does a registered memory read and then loads the result
// register; the load waits only while rsp holds an untaken word.
// A clear, and reset, run a sweep over all CAPACITY_FRAMES*MAX_CHANNELS
// entries (2048 by default) that zeroes one memory entry a cycle; req is not
// ready during the sweep. Reset is synchronous and active high.
//
module timestamped_audio_ring_buffer #(
  parameter int CAPACITY_FRAMES = 1024,
  parameter int MAX_CHANNELS    = 2
) (
  input  logic      clk,
  input  logic      rst,
  tarb_req_if.sink  req,
  tarb_rsp_if.source rsp,
  tarb_cfg_if.sink  cfg
);

  tarb_pkg::tarb_ctl_t ctl;
  tarb_pkg::tarb_sts_t sts;

  // Configuration writes are taken at any time.
  assign cfg.ready = 1'b1;

  tarb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tarb_dp #(
    .CAPACITY_FRAMES (CAPACITY_FRAMES),
    .MAX_CHANNELS    (MAX_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg.valid && cfg.ready),
    .cfg_count     (cfg.channel_count),
    .sample_time   (req.sample_time),
    .channel       (req.channel),
    .sample_in     (req.sample_in),
    .last_in_batch (req.last_in_batch),
    .ctl           (ctl),
    .sts           (sts),
    .sample_out    (rsp.sample_out),
    .in_window     (rsp.in_window)
  );

endmodule
